// ===== src/i2ctsr_pkg.sv =====
// Shared types and constants for the I2C target shadow register file.
package i2ctsr_pkg;

    localparam int STORE_BYTES_DEF = 128;
    localparam int NUM_FIELDS = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam logic [6:0] WB_RESET = 7'd16;

    localparam logic [2:0] REQ_BYTE = 3'd0;
    localparam logic [2:0] REQ_READ = 3'd1;
    localparam logic [2:0] REQ_STOP = 3'd2;
    localparam logic [2:0] REQ_LOCAL = 3'd3;
    localparam logic [2:0] REQ_TAKE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WB = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_A = 3'd1;

    typedef struct packed {
        logic [6:0] wb;
        logic       hit;
        logic [6:0] fs;
        logic [7:0] fend;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       com;
        logic       taken;
    } res_t;

endpackage

// ===== src/i2ctsr_ram.sv =====
// Single-port-write, single-port-read byte memory with registered read data.
module i2ctsr_ram #(
    parameter int DEPTH = 128,
    parameter int AW = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/i2ctsr_cfg.sv =====
// Configuration registers and string field lookup for the transaction start.
module i2ctsr_cfg
    import i2ctsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            txn_start,
    output cfg_t                  cfg
);

    logic [6:0]            wb_reg;
    logic [CFG_DATA_W-1:0] fld_reg [NUM_FIELDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg <= WB_RESET;
            for (int f = 0; f < NUM_FIELDS; f++) begin
                fld_reg[f] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index == CFG_WB) begin
                wb_reg <= cfg_data[6:0];
            end
            for (int f = 0; f < NUM_FIELDS; f++) begin
                if (cfg_index == CFG_FIELD_A + CFG_IDX_W'(f)) begin
                    fld_reg[f] <= cfg_data;
                end
            end
        end
    end

    // first enabled field whose start matches wins
    always_comb begin
        cfg.wb   = wb_reg;
        cfg.hit  = 1'b0;
        cfg.fs   = '0;
        cfg.fend = '0;
        for (int f = NUM_FIELDS - 1; f >= 0; f--) begin
            if (fld_reg[f][13:7] != 7'd0 && {1'b0, fld_reg[f][6:0]} == txn_start) begin
                cfg.hit  = 1'b1;
                cfg.fs   = fld_reg[f][6:0];
                cfg.fend = 8'(fld_reg[f][6:0]) + 8'(fld_reg[f][13:7]);
            end
        end
    end

endmodule

// ===== src/i2ctsr_core.sv =====
// Request sequencer with live and shadow stores, copy sweeps and clearing pass.
module i2ctsr_core
    import i2ctsr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int AW = $clog2(STORE_BYTES)
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_req,
    input  logic [7:0] in_data,
    input  logic [6:0] in_laddr,
    input  cfg_t       cfg,
    output logic [7:0] txn_start,
    output logic       res_valid,
    input  logic       res_ready,
    output res_t       res
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_COPY = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [AW-1:0] LAST = AW'(STORE_BYTES - 1);
    localparam logic [AW:0]   CNT_END = (AW+1)'(STORE_BYTES);
    localparam logic [8:0]    N9 = 9'(STORE_BYTES);

    logic [2:0]    state_reg, state_next;
    logic [2:0]    req_reg, req_next;
    logic [7:0]    data_reg, data_next;
    logic [7:0]    val_reg, val_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] start_reg, start_next;
    logic          seen_reg, seen_next;
    logic          has_reg, has_next;
    logic          pend_reg, pend_next;
    logic          dir_reg, dir_next;
    logic [AW:0]   cnt_reg, cnt_next;
    res_t          res_reg, res_next;

    logic          live_we, sh_we;
    logic [AW-1:0] live_wa, sh_wa, live_ra, sh_ra;
    logic [7:0]    live_wd, sh_wd, live_rd, sh_rd;
    logic [AW-1:0] copy_wa, ptr_inc;
    logic          ptr_wr_ok, in_field;

    i2ctsr_ram #(.DEPTH(STORE_BYTES), .AW(AW)) u_live (
        .aclk(aclk), .we(live_we), .waddr(live_wa), .wdata(live_wd),
        .raddr(live_ra), .rdata(live_rd)
    );

    i2ctsr_ram #(.DEPTH(STORE_BYTES), .AW(AW)) u_shadow (
        .aclk(aclk), .we(sh_we), .waddr(sh_wa), .wdata(sh_wd),
        .raddr(sh_ra), .rdata(sh_rd)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res       = res_reg;
    assign txn_start = 8'(start_reg);

    assign copy_wa   = AW'(cnt_reg - 1'b1);
    assign ptr_inc   = (ptr_reg == LAST) ? '0 : ptr_reg + 1'b1;
    assign ptr_wr_ok = 9'(ptr_reg) >= 9'(cfg.wb);
    assign in_field  = cfg.hit && 9'(copy_wa) >= 9'(cfg.fs) && 9'(copy_wa) < 9'(cfg.fend);

    always_comb begin
        state_next = state_reg;
        req_next   = req_reg;
        data_next  = data_reg;
        val_next   = val_reg;
        ptr_next   = ptr_reg;
        start_next = start_reg;
        seen_next  = seen_reg;
        has_next   = has_reg;
        pend_next  = pend_reg;
        dir_next   = dir_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        live_we    = 1'b0;
        live_wa    = copy_wa;
        live_wd    = sh_rd;
        live_ra    = ptr_reg;
        sh_we      = 1'b0;
        sh_wa      = copy_wa;
        sh_wd      = live_rd;
        sh_ra      = cnt_reg[AW-1:0];

        case (state_reg)
            S_CLR: begin
                live_we  = 1'b1;
                live_wa  = cnt_reg[AW-1:0];
                live_wd  = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[AW-1:0] == LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    req_next   = in_req;
                    data_next  = in_data;
                    val_next   = (in_req == REQ_LOCAL) ? {1'b0, in_laddr} : in_data;
                    res_next   = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                cnt_next = '0;
                case (req_reg)
                    REQ_BYTE: begin
                        if (!seen_reg) begin
                            state_next = S_MOD;
                        end else if (has_reg) begin
                            sh_we      = ptr_wr_ok;
                            sh_wa      = ptr_reg;
                            sh_wd      = data_reg;
                            ptr_next   = ptr_inc;
                            state_next = S_FIN;
                        end else begin
                            dir_next   = 1'b0;
                            state_next = S_COPY;
                        end
                    end
                    REQ_READ: begin
                        live_ra    = ptr_reg;
                        ptr_next   = ptr_inc;
                        state_next = S_RD;
                    end
                    REQ_STOP: begin
                        if (has_reg) begin
                            dir_next   = 1'b1;
                            state_next = S_COPY;
                        end else begin
                            seen_next  = 1'b0;
                            state_next = S_FIN;
                        end
                    end
                    REQ_LOCAL: begin
                        state_next = S_MOD;
                    end
                    REQ_TAKE: begin
                        res_next.taken = pend_reg;
                        pend_next      = 1'b0;
                        state_next     = S_FIN;
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_MOD: begin
                live_ra = val_reg[AW-1:0];
                if ({1'b0, val_reg} >= N9) begin
                    val_next = 8'({1'b0, val_reg} - N9);
                end else if (req_reg == REQ_BYTE) begin
                    ptr_next   = val_reg[AW-1:0];
                    start_next = val_reg[AW-1:0];
                    seen_next  = 1'b1;
                    has_next   = 1'b0;
                    state_next = S_FIN;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                res_next.rd = live_rd;
                state_next  = S_FIN;
            end
            S_COPY: begin
                live_ra  = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    if (dir_reg) begin
                        live_we = 1'b1;
                    end else begin
                        sh_we = 1'b1;
                        if (copy_wa == ptr_reg && ptr_wr_ok) begin
                            sh_wd = data_reg;
                        end else if (in_field) begin
                            sh_wd = '0;
                        end
                    end
                end
                if (cnt_reg == CNT_END) begin
                    if (dir_reg) begin
                        pend_next    = 1'b1;
                        res_next.com = 1'b1;
                        seen_next    = 1'b0;
                        has_next     = 1'b0;
                    end else begin
                        ptr_next = ptr_inc;
                        has_next = 1'b1;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            ptr_reg   <= '0;
            start_reg <= '0;
            seen_reg  <= 1'b0;
            has_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            start_reg <= start_next;
            seen_reg  <= seen_next;
            has_reg   <= has_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg  <= req_next;
        data_reg <= data_next;
        val_reg  <= val_next;
        dir_reg  <= dir_next;
        res_reg  <= res_next;
    end

endmodule

// ===== src/i2c_target_shadow_register_file.sv =====
// Top level of the I2C target shadow register file with result output register.
//
//  channel   ports                                         direction
//  s_        s_valid s_ready s_req_type s_data_byte s_local_address   in
//  m_        m_valid m_ready m_read_data m_committed m_update_taken   out
//  cfg_      cfg_valid cfg_ready cfg_index cfg_data                  in
//
// A first data byte or a committing stop runs one sweep over the whole memory;
// pointer bytes and local reads reduce their address by repeated subtraction of STORE_BYTES.
// After reset the live store is cleared one entry a cycle, and no items are taken meanwhile.
// A waiting result sits in the output register while the next item is taken.
module i2c_target_shadow_register_file
    import i2ctsr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_req_type,
    input  logic [7:0]            s_data_byte,
    input  logic [6:0]            s_local_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_read_data,
    output logic                  m_committed,
    output logic                  m_update_taken,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    res_t       res;
    logic [7:0] txn_start;
    logic       res_valid, res_ready;
    logic       m_valid_reg, m_valid_next;
    res_t       out_reg, out_next;

    i2ctsr_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .txn_start(txn_start), .cfg(cfg)
    );

    i2ctsr_core #(.STORE_BYTES(STORE_BYTES)) u_core (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_req(s_req_type), .in_data(s_data_byte), .in_laddr(s_local_address),
        .cfg(cfg), .txn_start(txn_start),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_read_data    = out_reg.rd;
    assign m_committed    = out_reg.com;
    assign m_update_taken = out_reg.taken;

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_committed && m_update_taken))
        else $error("commit and take flagged in one item");

    a_commit_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_committed || m_update_taken) |-> m_read_data == 8'd0)
        else $error("read data on a commit or take item");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready)
        else $error("item taken during clearing pass");

endmodule

// ===== sim/tb.sv =====
// Testbench for the I2C target shadow register file: predicted replies under directed and random traffic.
`timescale 1ns / 1ps

module tb;
    import i2ctsr_pkg::*;

    localparam int DEPTH = STORE_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [2:0] REQ_UNUSED_LO = REQ_TAKE + 3'd1;
    localparam logic [2:0] REQ_UNUSED_HI = '1;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_req_type = REQ_STOP;
    logic [7:0]            s_data_byte = '0;
    logic [6:0]            s_local_address = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_read_data;
    logic                  m_committed;
    logic                  m_update_taken;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_WB;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_gap_pct = 0;
    int recv_hold_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // predictor state
    logic [7:0]  live_mem [DEPTH] = '{default: 8'h00};
    logic [7:0]  shadow_mem [DEPTH] = '{default: 8'h00};
    int          reg_ptr = 0;
    int          txn_base = 0;
    bit          ptr_seen = 1'b0;
    bit          txn_data = 1'b0;
    bit          upd_pending = 1'b0;
    logic [6:0]  cfg_wbase = WB_RESET;
    logic [13:0] cfg_fields [NUM_FIELDS] = '{default: '0};

    res_t expected_replies [$];

    i2c_target_shadow_register_file uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_data_byte     (s_data_byte),
        .s_local_address (s_local_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_committed     (m_committed),
        .m_update_taken  (m_update_taken),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_hold_pct);
    end

    function automatic res_t predict_reply(logic [2:0] rq, logic [7:0] db, logic [6:0] la);
        res_t r;
        bit   cleared;
        r = '0;
        cleared = 1'b0;
        case (rq)
            REQ_BYTE: begin
                if (!ptr_seen) begin
                    reg_ptr = int'(db) % DEPTH;
                    txn_base = reg_ptr;
                    ptr_seen = 1'b1;
                    txn_data = 1'b0;
                end else begin
                    if (!txn_data) begin
                        foreach (shadow_mem[i]) shadow_mem[i] = live_mem[i];
                        // first enabled field starting at the txn start wins, no wrap
                        for (int f = 0; f < NUM_FIELDS; f++) begin
                            if (!cleared && cfg_fields[f][13:7] != 0
                                    && int'(cfg_fields[f][6:0]) == txn_base) begin
                                for (int i = 0; i < int'(cfg_fields[f][13:7]); i++) begin
                                    if (txn_base + i < DEPTH) shadow_mem[txn_base + i] = '0;
                                end
                                cleared = 1'b1;
                            end
                        end
                    end
                    if (reg_ptr >= int'(cfg_wbase)) shadow_mem[reg_ptr] = db;
                    reg_ptr = (reg_ptr + 1) % DEPTH;
                    txn_data = 1'b1;
                end
            end
            REQ_READ: begin
                r.rd = live_mem[reg_ptr];
                reg_ptr = (reg_ptr + 1) % DEPTH;
            end
            REQ_STOP: begin
                if (txn_data) begin
                    foreach (live_mem[i]) live_mem[i] = shadow_mem[i];
                    upd_pending = 1'b1;
                    r.com = 1'b1;
                end
                ptr_seen = 1'b0;
                txn_data = 1'b0;
            end
            REQ_LOCAL: r.rd = live_mem[int'(la) % DEPTH];
            REQ_TAKE: begin
                if (upd_pending) begin
                    r.taken = 1'b1;
                    upd_pending = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: unexpected reply rd=%02h com=%0d taken=%0d",
                                 m_read_data, m_committed, m_update_taken);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_read_data !== want.rd || m_committed !== want.com
                            || m_update_taken !== want.taken) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tb: mismatch expected rd=%02h com=%0d taken=%0d, got rd=%02h com=%0d taken=%0d",
                                     want.rd, want.com, want.taken,
                                     m_read_data, m_committed, m_update_taken);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_replies.push_back(predict_reply(s_req_type, s_data_byte,
                                                         s_local_address));
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WB)
                    cfg_wbase = cfg_data[6:0];
                else if (cfg_index >= CFG_FIELD_A && cfg_index < CFG_FIELD_A + NUM_FIELDS)
                    cfg_fields[cfg_index - CFG_FIELD_A] = cfg_data;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    task automatic push_request(input logic [2:0] rq, input logic [7:0] db,
                                input logic [6:0] la);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rq;
        s_data_byte <= db;
        s_local_address <= la;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_replies.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [13:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [6:0] wb, input logic [13:0] fa, input logic [13:0] fb,
                             input logic [13:0] fc, input logic [13:0] fd,
                             input logic [13:0] fe);
        write_reg(CFG_WB, {7'd0, wb});
        write_reg(CFG_FIELD_A, fa);
        write_reg(CFG_FIELD_A + 3'd1, fb);
        write_reg(CFG_FIELD_A + 3'd2, fc);
        write_reg(CFG_FIELD_A + 3'd3, fd);
        write_reg(CFG_FIELD_A + 3'd4, fe);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [13:0] text_word(int len, int start);
        return {7'(len), 7'(start)};
    endfunction

    function automatic logic [13:0] random_text_word();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return {7'd0, 7'($urandom)};
        if (k < 8) return {7'($urandom_range(1, 12)), 7'($urandom)};
        return 14'($urandom);
    endfunction

    // bias toward field starts and the top of the store; bit 7 is random
    function automatic logic [7:0] pick_pointer();
        int k;
        logic [6:0] a;
        k = $urandom_range(0, 9);
        if (k < 4)
            a = cfg_fields[$urandom_range(0, NUM_FIELDS - 1)][6:0];
        else if (k < 6)
            a = 7'($urandom_range(DEPTH - 8, DEPTH - 1));
        else
            a = 7'($urandom);
        return {1'($urandom), a};
    endfunction

    task automatic random_traffic(input int count);
        int items;
        int kind;
        int n;
        logic [2:0] rq;
        items = 0;
        while (items < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                push_request(REQ_BYTE, pick_pointer(), 7'($urandom));
                n = $urandom_range(0, 99);
                n = (n < 8) ? 0 : (n < 94) ? $urandom_range(1, 6) : $urandom_range(7, DEPTH + 4);
                repeat (n) push_request(REQ_BYTE, 8'($urandom), 7'($urandom));
                items += n + 1;
                // a missing stop now and then
                if ($urandom_range(0, 9) != 0) begin
                    push_request(REQ_STOP, 8'($urandom), 7'($urandom));
                    items++;
                end
            end else if (kind < 65) begin
                if ($urandom_range(0, 4) != 0) begin
                    push_request(REQ_BYTE, pick_pointer(), 7'($urandom));
                    items++;
                end
                n = $urandom_range(1, 6);
                repeat (n) push_request(REQ_READ, 8'($urandom), 7'($urandom));
                push_request(REQ_STOP, 8'($urandom), 7'($urandom));
                items += n + 1;
            end else if (kind < 75) begin
                push_request(REQ_LOCAL, 8'($urandom), 7'($urandom));
                items++;
            end else if (kind < 85) begin
                push_request(REQ_TAKE, 8'($urandom), 7'($urandom));
                items++;
            end else begin
                rq = 3'($urandom_range(0, REQ_UNUSED_HI));
                push_request(rq, 8'($urandom), 7'($urandom));
                if (rq < REQ_UNUSED_LO) items++;
            end
        end
    endtask

    task automatic test_directed_cases();
        drain_replies();
        // a and b share a start, c runs off the end, d is disabled
        configure(WB_RESET, text_word(4, 20), text_word(10, 20), text_word(127, 127),
                  text_word(0, 5), text_word(3, 0));
        push_request(REQ_READ, 8'h00, 7'h00);
        push_request(REQ_TAKE, 8'h00, 7'h00);
        push_request(REQ_STOP, 8'h00, 7'h00);
        push_request(REQ_UNUSED_LO, 8'hFF, 7'h7F);
        push_request(REQ_UNUSED_HI, 8'hFF, 7'h7F);
        push_request(REQ_BYTE, 8'hFF, 7'h00);
        push_request(REQ_BYTE, 8'hA5, 7'h00);
        push_request(REQ_BYTE, 8'h00, 7'h00);
        push_request(REQ_STOP, 8'h00, 7'h00);
        push_request(REQ_TAKE, 8'h00, 7'h00);
        push_request(REQ_TAKE, 8'h00, 7'h00);
        push_request(REQ_LOCAL, 8'h00, 7'h7F);
        push_request(REQ_LOCAL, 8'h00, 7'h00);
        push_request(REQ_BYTE, 8'd22, 7'h00);
        push_request(REQ_BYTE, 8'hFF, 7'h00);
        push_request(REQ_BYTE, 8'hFF, 7'h00);
        push_request(REQ_BYTE, 8'hFF, 7'h00);
        push_request(REQ_STOP, 8'h00, 7'h00);
        push_request(REQ_BYTE, 8'd20, 7'h00);
        push_request(REQ_BYTE, 8'h11, 7'h00);
        push_request(REQ_STOP, 8'h00, 7'h00);
        push_request(REQ_LOCAL, 8'h00, 7'd22);
        push_request(REQ_LOCAL, 8'h00, 7'd24);
        push_request(REQ_BYTE, 8'd126, 7'h00);
        push_request(REQ_READ, 8'h00, 7'h00);
        push_request(REQ_READ, 8'h00, 7'h00);
        push_request(REQ_READ, 8'h00, 7'h00);
        push_request(REQ_STOP, 8'h00, 7'h00);
    endtask

    task automatic test_base_zero();
        drain_replies();
        configure(7'd0, random_text_word(), random_text_word(), random_text_word(),
                  random_text_word(), random_text_word());
        random_traffic(400);
    endtask

    task automatic test_high_extremes();
        drain_replies();
        send_gap_pct <= 88;
        recv_hold_pct <= 32;
        configure(7'h7F, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        random_traffic(250);
    endtask

    task automatic test_random_settings();
        logic [13:0] fa;
        drain_replies();
        send_gap_pct <= 0;
        recv_hold_pct <= 0;
        fa = random_text_word();
        configure(7'($urandom), fa, {7'($urandom_range(1, 12)), fa[6:0]}, random_text_word(),
                  random_text_word(), random_text_word());
        random_traffic(300);
    endtask

    task automatic test_pause_and_resume();
        drain_replies();
        configure(WB_RESET, '0, '0, '0, '0, '0);
        random_traffic(120);
        drain_replies();
        random_traffic(130);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        send_gap_pct <= 32;
        recv_hold_pct <= 88;
        test_directed_cases();
        test_base_zero();
        test_high_extremes();
        test_random_settings();
        test_pause_and_resume();
        drain_replies();
        repeat (DEPTH + 8) @(posedge aclk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
